[sv/bzt_pkg.sv]
package bzt_pkg;

  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STRENGTH_W = 17;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned BAND_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // shared divider operand widths
  localparam int unsigned DVD_W = 64;
  localparam int unsigned DVS_W = 48;

  localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST = 16'd11916;
  localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST = 16'd2570;
  localparam logic [LEN_W-1:0]   WINDOW_LEN_RST = 7'd20;
  localparam logic [BAND_W-1:0]  BAND_MULT_RST  = 16'd8192;

  localparam logic [STRENGTH_W-1:0] STRENGTH_FULL = 17'd65536;

  typedef enum logic [KIND_W-1:0] {
    KIND_HOLD = 2'd0,
    KIND_BUY  = 2'd1,
    KIND_SELL = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_ALPHA = 2'd0,
    REG_SLOW_ALPHA = 2'd1,
    REG_WINDOW_LEN = 2'd2,
    REG_BAND_MULT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMA_F,
    S_EMA_S,
    S_SQUARE,
    S_ACCUM,
    S_MEAN,
    S_MEAN_W,
    S_VAR,
    S_VAR_W,
    S_ROOT,
    S_ROOT_W,
    S_ZDIV,
    S_ZDIV_W,
    S_DECIDE,
    S_SDIV,
    S_SDIV_W,
    S_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/bzt_if.sv]
interface bzt_tick_if;
  import bzt_pkg::*;
  logic                valid;
  logic                ready;
  logic [PRICE_W-1:0]  tick_price;
  logic [TIME_W-1:0]   tick_time;
  modport source (output valid, tick_price, tick_time, input ready);
  modport sink   (input valid, tick_price, tick_time, output ready);
endinterface

interface bzt_signal_if;
  import bzt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     signal_kind;
  logic [STRENGTH_W-1:0] signal_strength;
  logic [TIME_W-1:0]     signal_time;
  modport source (output valid, signal_kind, signal_strength, signal_time, input ready);
  modport sink   (input valid, signal_kind, signal_strength, signal_time, output ready);
endinterface

interface bzt_cfg_if;
  import bzt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/band_zscore_trend_signal_unit.sv]
// channel   dir  handshake      payload
// tick_i    in   valid/ready    tick_price[31:0], tick_time[63:0]
// signal_o  out  valid/ready    signal_kind[1:0], signal_strength[16:0], signal_time[63:0]
// cfg_i     in   valid/ready    index[1:0], data[15:0]
//
// One tick at a time: the z-score division is skipped when the deviation is zero, and
// the strength division runs only for a buy or sell whose excess is below the band;
// each division uses the shared 64-step divider, and the deviation the 32-step root.
// The window lives in a one-port-read RAM; rolling sums are kept in registers.
// rst_ni clears averages and window bookkeeping and sets registers to their defaults; the RAM needs no clear.
// A new tick is taken while a result waits; a stalled result holds the sequencer.
module band_zscore_trend_signal_unit #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bzt_tick_if.sink      tick_i,
  bzt_signal_if.source  signal_o,
  bzt_cfg_if.sink       cfg_i
);
  import bzt_pkg::*;

  localparam int unsigned AW    = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W = PRICE_W + CNT_W;
  localparam int unsigned SQ_W  = 48 + CNT_W;

  // configuration registers
  logic [ALPHA_W-1:0] fast_alpha_q, slow_alpha_q;
  logic [LEN_W-1:0]   window_len_q;
  logic [BAND_W-1:0]  band_mult_q;
  logic               cfg_we;
  logic               len_we;

  // block state
  state_e             state_q, state_d;
  logic [PRICE_W-1:0] fast_avg_q, slow_avg_q;
  logic               seeded_q;
  logic [AW-1:0]      slot_q;
  logic [CNT_W-1:0]   fill_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SQ_W-1:0]    sqsum_q;

  // per-tick working registers
  logic [PRICE_W-1:0] price_q;
  logic [TIME_W-1:0]  time_q;
  logic [AW-1:0]      cur_slot_q;
  logic [PRICE_W-1:0] old_q;
  logic [47:0]        prod_a_q;
  logic [48:0]        prod_b_q;
  logic [63:0]        sq_new_q, sq_old_q;
  logic [PRICE_W-1:0] mean_q;
  logic [63:0]        meansq_q;
  logic [47:0]        var_q;
  logic [31:0]        sd_q;
  logic [31:0]        diff_q;
  logic               above_q, below_q;
  logic [47:0]        zmag_q;
  logic [KIND_W-1:0]  kind_q;
  logic [STRENGTH_W-1:0] strength_q;

  // output register
  logic                  out_valid_q;
  logic [KIND_W-1:0]     out_kind_q;
  logic [STRENGTH_W-1:0] out_strength_q;
  logic [TIME_W-1:0]     out_time_q;

  // control strobes
  logic     tick_take;
  logic     out_load;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     sqrt_start;
  logic     sqrt_done;
  logic [31:0] sqrt_root;
  logic [PRICE_W-1:0] ram_rdata;
  logic     ram_we;

  // derived values
  logic [CNT_W-1:0] cap;
  logic [AW-1:0]    slot_eff;
  logic [CNT_W-1:0] slot_inc;
  logic             evict;
  logic [49:0]      ema_acc;
  logic [PRICE_W-1:0] ema_val;
  logic [19:0]      band;
  logic [47:0]      excess;
  logic [47:0]      msq;
  logic [47:0]      var_quo;
  logic             fast_over_slow;
  kind_e            kind_sel;

  // effective window length
  always_comb begin
    if (window_len_q == '0) begin
      cap = CNT_W'(1);
    end else if (int'(window_len_q) > WINDOW_MAX) begin
      cap = CNT_W'(WINDOW_MAX);
    end else begin
      cap = CNT_W'(window_len_q);
    end
  end

  assign slot_eff = (CNT_W'(slot_q) >= cap) ? '0 : slot_q;
  assign slot_inc = CNT_W'(cur_slot_q) + CNT_W'(1);
  assign evict    = (fill_q >= cap);

  assign ema_acc = 50'(prod_a_q) + 50'(prod_b_q) + 50'd32768;
  assign ema_val = ema_acc[47:16];

  assign band           = {band_mult_q, 4'b0000};
  assign excess         = zmag_q - 48'(band);
  assign msq            = meansq_q[63:16];
  assign var_quo        = div_rsp.quotient[47:0];
  assign fast_over_slow = (fast_avg_q > slow_avg_q);

  always_comb begin
    kind_sel = KIND_HOLD;
    if (zmag_q > 48'(band)) begin
      if (fast_over_slow && below_q) begin
        kind_sel = KIND_BUY;
      end else if (!fast_over_slow && above_q) begin
        kind_sel = KIND_SELL;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (tick_i.valid) state_d = S_EMA_F;
      S_EMA_F:  state_d = S_EMA_S;
      S_EMA_S:  state_d = S_SQUARE;
      S_SQUARE: state_d = S_ACCUM;
      S_ACCUM:  state_d = S_MEAN;
      S_MEAN:   state_d = S_MEAN_W;
      S_MEAN_W: if (div_rsp.done) state_d = S_VAR;
      S_VAR:    state_d = S_VAR_W;
      S_VAR_W:  if (div_rsp.done) state_d = S_ROOT;
      S_ROOT:   state_d = S_ROOT_W;
      S_ROOT_W: begin
        if (sqrt_done) state_d = (sqrt_root == '0) ? S_DECIDE : S_ZDIV;
      end
      S_ZDIV:   state_d = S_ZDIV_W;
      S_ZDIV_W: if (div_rsp.done) state_d = S_DECIDE;
      S_DECIDE: begin
        if (kind_sel != KIND_HOLD && excess < 48'(band)) state_d = S_SDIV;
        else state_d = S_OUT;
      end
      S_SDIV:   state_d = S_SDIV_W;
      S_SDIV_W: if (div_rsp.done) state_d = S_OUT;
      S_OUT:    if (!out_valid_q || signal_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    tick_take        = 1'b0;
    out_load         = 1'b0;
    ram_we           = 1'b0;
    sqrt_start       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      S_IDLE:  tick_take = tick_i.valid;
      S_ACCUM: ram_we = 1'b1;
      S_MEAN: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(sum_q);
        div_req.divisor  = DVS_W'(fill_q);
      end
      S_VAR: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(sqsum_q);
        div_req.divisor  = DVS_W'(fill_q);
      end
      S_ROOT:  sqrt_start = 1'b1;
      S_ZDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'({diff_q, 16'h0000});
        div_req.divisor  = DVS_W'(sd_q);
      end
      S_SDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'({excess, 16'h0000});
        div_req.divisor  = DVS_W'(band);
      end
      S_OUT:   out_load = !out_valid_q || signal_o.ready;
      default: ;
    endcase
  end

  assign tick_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign cfg_we       = cfg_i.valid;
  assign len_we       = cfg_we && (cfg_i.index == REG_WINDOW_LEN);

  // window store
  bzt_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW_MAX)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_slot_q),
    .wdata_i (price_q),
    .raddr_i (slot_eff),
    .rdata_o (ram_rdata)
  );

  bzt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bzt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i ({var_q, 16'h0000}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fast_alpha_q <= FAST_ALPHA_RST;
      slow_alpha_q <= SLOW_ALPHA_RST;
      window_len_q <= WINDOW_LEN_RST;
      band_mult_q  <= BAND_MULT_RST;
      fast_avg_q   <= '0;
      slow_avg_q   <= '0;
      seeded_q     <= 1'b0;
      slot_q       <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      sqsum_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes, a window length write empties the window
      if (cfg_we) begin
        case (cfg_i.index)
          REG_FAST_ALPHA: fast_alpha_q <= cfg_i.data;
          REG_SLOW_ALPHA: slow_alpha_q <= cfg_i.data;
          REG_WINDOW_LEN: window_len_q <= cfg_i.data[LEN_W-1:0];
          REG_BAND_MULT:  band_mult_q  <= cfg_i.data;
          default: ;
        endcase
      end

      if (state_q == S_EMA_S) begin
        fast_avg_q <= seeded_q ? ema_val : price_q;
      end
      if (state_q == S_SQUARE) begin
        slow_avg_q <= seeded_q ? ema_val : price_q;
        seeded_q   <= 1'b1;
      end

      // rolling window update
      if (len_we) begin
        slot_q  <= '0;
        fill_q  <= '0;
        sum_q   <= '0;
        sqsum_q <= '0;
      end else if (state_q == S_ACCUM) begin
        slot_q <= (slot_inc >= cap) ? '0 : AW'(slot_inc);
        if (evict) begin
          fill_q  <= cap;
          sum_q   <= sum_q - SUM_W'(old_q) + SUM_W'(price_q);
          sqsum_q <= sqsum_q - SQ_W'(sq_old_q[63:16]) + SQ_W'(sq_new_q[63:16]);
        end else begin
          fill_q  <= fill_q + CNT_W'(1);
          sum_q   <= sum_q + SUM_W'(price_q);
          sqsum_q <= sqsum_q + SQ_W'(sq_new_q[63:16]);
        end
      end

      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (signal_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-tick datapath
  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      price_q <= tick_i.tick_price;
      time_q  <= tick_i.tick_time;
    end
    case (state_q)
      S_EMA_F: begin
        cur_slot_q <= slot_eff;
        prod_a_q   <= fast_alpha_q * price_q;
        prod_b_q   <= ({1'b0, ~fast_alpha_q} + 17'd1) * fast_avg_q;
      end
      S_EMA_S: begin
        old_q    <= ram_rdata;
        prod_a_q <= slow_alpha_q * price_q;
        prod_b_q <= ({1'b0, ~slow_alpha_q} + 17'd1) * slow_avg_q;
        sq_new_q <= price_q * price_q;
      end
      S_SQUARE: sq_old_q <= old_q * old_q;
      S_MEAN_W: if (div_rsp.done) mean_q <= div_rsp.quotient[PRICE_W-1:0];
      S_VAR: begin
        meansq_q <= mean_q * mean_q;
        if (price_q >= mean_q) begin
          diff_q  <= price_q - mean_q;
          above_q <= (price_q != mean_q);
          below_q <= 1'b0;
        end else begin
          diff_q  <= mean_q - price_q;
          above_q <= 1'b0;
          below_q <= 1'b1;
        end
      end
      S_VAR_W: if (div_rsp.done) var_q <= (var_quo > msq) ? var_quo - msq : '0;
      S_ROOT_W: begin
        if (sqrt_done) begin
          sd_q   <= sqrt_root;
          zmag_q <= '0;
        end
      end
      S_ZDIV_W: if (div_rsp.done) zmag_q <= div_rsp.quotient[47:0];
      S_DECIDE: begin
        kind_q     <= kind_sel;
        strength_q <= (kind_sel == KIND_HOLD) ? '0 : STRENGTH_FULL;
      end
      S_SDIV_W: if (div_rsp.done) strength_q <= div_rsp.quotient[STRENGTH_W-1:0];
      default: ;
    endcase
    if (out_load) begin
      out_kind_q     <= kind_q;
      out_strength_q <= strength_q;
      out_time_q     <= time_q;
    end
  end

  assign signal_o.valid           = out_valid_q;
  assign signal_o.signal_kind     = out_kind_q;
  assign signal_o.signal_strength = out_strength_q;
  assign signal_o.signal_time     = out_time_q;

endmodule

[sv/bzt_ram.sv]
module bzt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/bzt_div.sv]
module bzt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bzt_pkg::div_req_t req_i,
  output bzt_pkg::div_rsp_t rsp_o
);
  import bzt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   dvs_ext;

  assign rem_sh  = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign dvs_ext = {1'b0, dvs_q};

  // one restoring quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= dvs_ext) begin
        rem_d = rem_sh - dvs_ext;
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[sv/bzt_sqrt.sv]
module bzt_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] val_q, val_d;
  logic [31:0] root_q, root_d;
  logic [34:0] rem_q, rem_d;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  assign rem_sh = {rem_q[32:0], val_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};

  // two radicand bits and one root bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      val_d  = value_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      val_d = {val_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
